// ===== hdl/ldf_pkg.sv =====
`default_nettype none
package ldf_pkg;

  localparam int LEN_W = 32;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_BADEND = 2'd2;
  localparam logic [1:0] KIND_CLOSED = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       close_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t entry;
  } wr_t;

endpackage
`default_nettype wire

// ===== hdl/ldf_front.sv =====
`default_nettype none
module ldf_front #(
  parameter int LENGTH_BYTES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire ldf_pkg::in_item_t item,
  output ldf_pkg::wr_t          wr,
  output logic                  halted
);
  import ldf_pkg::*;

  localparam int HCW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [HCW-1:0] HC_LAST = HCW'(LENGTH_BYTES - 1);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_BODY   = 4'b0010,
    PH_TERM   = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  phase_t             phase, phase_next;
  logic [HCW-1:0]     header_count, header_count_next;
  logic [LEN_W-1:0]   body_length, body_length_next;
  logic [LEN_W-1:0]   bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0]   shifted;

  assign shifted = {body_length[LEN_W-9:0], item.data_byte};
  assign halted  = (phase == PH_HALT);

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    body_length_next     = body_length;
    bytes_remaining_next = bytes_remaining;
    wr.valid             = 1'b0;
    wr.entry.kind        = KIND_BYTE;
    wr.entry.payload     = 8'd0;
    if (accept && (phase != PH_HALT)) begin
      if (item.close_stream) begin
        phase_next    = PH_HALT;
        wr.valid      = 1'b1;
        wr.entry.kind = KIND_CLOSED;
      end else begin
        case (phase)
          PH_HEADER: begin
            body_length_next = shifted;
            if (header_count == HC_LAST) begin
              header_count_next    = '0;
              bytes_remaining_next = shifted;
              phase_next           = (shifted == '0) ? PH_TERM : PH_BODY;
            end else begin
              header_count_next = header_count + HCW'(1);
            end
          end
          PH_BODY: begin
            bytes_remaining_next = bytes_remaining - LEN_W'(1);
            if (bytes_remaining == LEN_W'(1)) begin
              phase_next = PH_TERM;
            end
            wr.valid         = 1'b1;
            wr.entry.kind    = KIND_BYTE;
            wr.entry.payload = item.data_byte;
          end
          PH_TERM: begin
            wr.valid = 1'b1;
            if (item.data_byte == 8'd0) begin
              phase_next           = PH_HEADER;
              header_count_next    = '0;
              body_length_next     = '0;
              bytes_remaining_next = '0;
              wr.entry.kind        = KIND_ACCEPT;
            end else begin
              phase_next    = PH_HALT;
              wr.entry.kind = KIND_BADEND;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      body_length     <= '0;
      bytes_remaining <= '0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      body_length     <= body_length_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ldf_queue.sv =====
`default_nettype none
module ldf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ldf_pkg::wr_t      wr,
  input  wire logic              pop,
  output ldf_pkg::out_item_t     head,
  output logic                   empty,
  output logic                   full
);
  import ldf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

  out_item_t       slots [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = wr.valid;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/length_prefixed_packet_deframer.sv =====
// Length-prefixed packet deframer. Takes one stream byte per beat: each frame
// is a LENGTH_BYTES big-endian body length, the body bytes, then a zero
// terminator. Every body byte comes out as kind 0, a good terminator as kind 1
// (also for an empty body), a nonzero terminator as kind 2 and a close as
// kind 3; after kinds 2 and 3 the block halts and gives nothing until reset.
// One byte is accepted every cycle while full is low; its result is written
// to the result queue and shows on result once those ahead are popped. full
// rises only when DEPTH results wait unpopped, so the byte rate is set by the
// reader alone. No clearing pass after reset.
`default_nettype none
module length_prefixed_packet_deframer #(
  parameter int LENGTH_BYTES = 4,
  parameter int DEPTH        = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire ldf_pkg::in_item_t  item,
  output logic                    empty,
  input  wire logic               pop,
  output ldf_pkg::out_item_t      result
);
  import ldf_pkg::*;

  wr_t  wr;
  logic halted;
  logic accept;

  assign accept = push && !full;

  ldf_front #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .wr     (wr),
    .halted (halted)
  );

  ldf_queue #(
    .DEPTH(DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .pop   (pop),
    .head  (result),
    .empty (empty),
    .full  (full)
  );

  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("deframer left halt without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !wr.valid) else $error("result written while halted");

  a_close_result: assert property (@(posedge clk) disable iff (rst)
    (accept && item.close_stream && !halted) |=> (!empty && halted))
    else $error("close beat gave no result");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.kind != KIND_BYTE)) |-> (result.payload == 8'd0))
    else $error("nonzero payload on status result");

endmodule
`default_nettype wire
